@@ hw/rtl/tlnrf_pkg.sv @@
// Package for the TELNET receive filter: command codes, parser state type,
// reply policy function and the parser result struct. No dependencies.
package tlnrf_pkg;

    // TELNET command bytes
    localparam logic [7:0] T_IAC  = 8'd255;
    localparam logic [7:0] T_DONT = 8'd254;
    localparam logic [7:0] T_DO   = 8'd253;
    localparam logic [7:0] T_WONT = 8'd252;
    localparam logic [7:0] T_WILL = 8'd251;
    localparam logic [7:0] T_SB   = 8'd250;
    localparam logic [7:0] T_SE   = 8'd240;

    // Option codes with a non-default policy
    localparam logic [7:0] OPT_BINARY = 8'd0;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;

    // Received verb, stored as (verb - WILL)
    localparam logic [1:0] VERB_WILL = 2'd0;
    localparam logic [1:0] VERB_WONT = 2'd1;
    localparam logic [1:0] VERB_DO   = 2'd2;
    localparam logic [1:0] VERB_DONT = 2'd3;

    // Result count codes per input byte
    localparam logic [1:0] RES_NONE  = 2'd0;
    localparam logic [1:0] RES_ONE   = 2'd1;
    localparam logic [1:0] RES_THREE = 2'd3;

    // Output queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PS_DATA   = 3'd0,
        PS_IAC    = 3'd1,
        PS_OPTION = 3'd2,
        PS_SUB    = 3'd3,
        PS_SUBIAC = 3'd4
    } parse_state_t;

    // Results caused by one input byte
    typedef struct packed {
        logic [1:0] count;      // RES_NONE, RES_ONE or RES_THREE
        logic       to_network; // replies go toward the network
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } parse_res_t;

    // Negotiation policy: answer to a received verb for an option
    function automatic logic [7:0] choose_reply(input logic [1:0] verb,
                                                input logic [7:0] opt);
        logic [7:0] reply;
        reply = T_WONT;
        case (opt) inside
            OPT_BINARY:
            begin
                case (verb)
                    VERB_WILL: reply = T_DO;
                    VERB_WONT: reply = T_DONT;
                    VERB_DO:   reply = T_WILL;
                    default:   reply = T_WONT;
                endcase
            end
            OPT_ECHO, OPT_SGA:
            begin
                if (verb == VERB_WILL)
                    reply = T_DO;
                else if (verb == VERB_DO && opt == OPT_SGA)
                    reply = T_WILL;
                else if (verb == VERB_WONT)
                    reply = T_DONT;
                else
                    reply = T_WONT;
            end
            default:
            begin
                reply = (verb == VERB_WILL || verb == VERB_WONT) ? T_DONT : T_WONT;
            end
        endcase
        return reply;
    endfunction

endpackage

@@ hw/rtl/tlnrf_parser.sv @@
// TELNET command parser: state machine over received bytes that yields
// zero, one or three result bytes per step. Depends on tlnrf_pkg.
module tlnrf_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,     // consume rx_byte this cycle
    input  logic [7:0]             rx_byte,
    output tlnrf_pkg::parse_res_t  res
);
    import tlnrf_pkg::*;

    parse_state_t state_reg, state_next;
    logic [1:0]   verb_reg, verb_next;

    // Next state and pending verb
    always_comb
    begin
        state_next = state_reg;
        verb_next  = verb_reg;
        case (state_reg)
            PS_DATA:
            begin
                if (rx_byte == T_IAC)
                    state_next = PS_IAC;
            end
            PS_IAC:
            begin
                case (rx_byte) inside
                    T_IAC: state_next = PS_DATA;
                    [T_WILL:T_DONT]:
                    begin
                        verb_next  = 2'(rx_byte - T_WILL);
                        state_next = PS_OPTION;
                    end
                    T_SB:    state_next = PS_SUB;
                    default: state_next = PS_DATA;
                endcase
            end
            PS_OPTION:
            begin
                state_next = PS_DATA;
                verb_next  = VERB_WILL;
            end
            PS_SUB:
            begin
                if (rx_byte == T_IAC)
                    state_next = PS_SUBIAC;
            end
            PS_SUBIAC:
            begin
                state_next = (rx_byte == T_SE) ? PS_DATA : PS_SUB;
            end
            default: state_next = PS_DATA;
        endcase
    end

    // Result bytes for the current byte
    always_comb
    begin
        res.count      = RES_NONE;
        res.to_network = 1'b0;
        res.b0         = rx_byte;
        res.b1         = choose_reply(verb_reg, rx_byte);
        res.b2         = rx_byte;
        case (state_reg)
            PS_DATA:
            begin
                if (rx_byte != T_IAC)
                    res.count = RES_ONE;
            end
            PS_IAC:
            begin
                if (rx_byte == T_IAC)
                    res.count = RES_ONE;
            end
            PS_OPTION:
            begin
                res.count      = RES_THREE;
                res.to_network = 1'b1;
                res.b0         = T_IAC;
            end
            default: res.count = RES_NONE;
        endcase
    end

    // Advance only on a consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_DATA;
            verb_reg  <= VERB_WILL;
        end
        else if (step)
        begin
            state_reg <= state_next;
            verb_reg  <= verb_next;
        end
    end

endmodule

@@ hw/rtl/telnet_receive_filter_core.sv @@
// Top level of the TELNET receive filter: input register, parser and a
// small output queue. Depends on tlnrf_pkg and tlnrf_parser.
//
//  Channel   Dir  Beat holds                          Accepted when
//  s_axis    in   tdata[7:0] rx_byte                  s_axis_tvalid & s_axis_tready
//  m_axis    out  tdata[7:0] out_byte, tuser[0]       m_axis_tvalid & m_axis_tready
//                 to_network, tlast last
//
// One byte is taken per cycle while the queue has room; a byte passes from the
// input register through the combinational parser into the output queue. A
// negotiation reply puts three beats in the queue. The input register moves on
// only when the queue has room for three beats after this cycle's output beat.
// Reset clears the parser state, the input valid and the queue.
module telnet_receive_filter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [0:0] m_axis_tuser,   // [0] to_network
    output logic       m_axis_tlast
);
    import tlnrf_pkg::*;

    typedef struct packed {
        logic       to_network;
        logic       last;
        logic [7:0] data;
    } qent_t;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             advance;
    logic             pop;
    logic [QCW-1:0]   count_reg, count_next, count_after_pop;
    logic [QAW-1:0]   head_reg, tail_reg;
    logic [QCW-1:0]   push_n;
    parse_res_t       res;
    qent_t            queue_reg [QDEPTH];

    tlnrf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    // Handshake and queue room
    assign pop             = m_axis_tvalid && m_axis_tready;
    assign count_after_pop = count_reg - QCW'(pop);
    assign advance         = in_valid_reg && (count_after_pop <= QCW'(QDEPTH - 3));
    assign s_axis_tready   = !in_valid_reg || advance;
    assign push_n          = advance ? QCW'(res.count) : '0;
    assign count_next      = count_after_pop + push_n;

    // Hold the accepted beat until the parser consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    // Queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (pop)
                head_reg <= head_reg + QAW'(1);
            tail_reg <= tail_reg + QAW'(push_n);
        end
    end

    // Write up to three result beats at the tail
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (res.count == RES_ONE)
            begin
                queue_reg[tail_reg] <= '{to_network: res.to_network, last: 1'b1,
                                         data: res.b0};
            end
            else if (res.count == RES_THREE)
            begin
                queue_reg[tail_reg] <= '{to_network: res.to_network, last: 1'b0,
                                         data: res.b0};
                queue_reg[tail_reg + QAW'(1)] <= '{to_network: res.to_network,
                                                   last: 1'b0, data: res.b1};
                queue_reg[tail_reg + QAW'(2)] <= '{to_network: res.to_network,
                                                   last: 1'b1, data: res.b2};
            end
        end
    end

    // Present the head beat
    assign m_axis_tvalid   = (count_reg != '0);
    assign m_axis_tdata    = queue_reg[head_reg].data;
    assign m_axis_tuser[0] = queue_reg[head_reg].to_network;
    assign m_axis_tlast    = queue_reg[head_reg].last;

endmodule
